### hw/rtl/olarb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olarb_pkg
// Shared types and constants for the occupancy light arbiter.
// ----------------------------------------------------------------------------
package olarb_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes, at byte address 4*index
	typedef enum logic [2:0] {
		REG_LONG_PRESS    = 3'd0,
		REG_TEST_WINDOW   = 3'd1,
		REG_HUB_TTL       = 3'd2,
		REG_MAX_DISTANCE  = 3'd3,
		REG_DARK_LUX      = 3'd4,
		REG_PRESENCE_HOLD = 3'd5,
		REG_LUX_MAX_AGE   = 3'd6
	} reg_idx_t;

	localparam logic [31:0] LONG_PRESS_RST    = 32'd5000;
	localparam logic [31:0] TEST_WINDOW_RST   = 32'd10000;
	localparam logic [31:0] HUB_TTL_RST       = 32'd60000;
	localparam logic [15:0] MAX_DISTANCE_RST  = 16'd300;
	localparam logic [15:0] DARK_LUX_RST      = 16'd50;
	localparam logic [31:0] PRESENCE_HOLD_RST = 32'd30000;
	localparam logic [31:0] LUX_MAX_AGE_RST   = 32'd300000;   // five minutes
	localparam logic [15:0] LUX_LEVEL_RST     = 16'd1000;

	localparam logic REASON_BUTTON = 1'b0;
	localparam logic REASON_AUTO   = 1'b1;

	typedef struct packed {
		logic [31:0] long_hold_ms;
		logic [31:0] test_window_ms;
		logic [31:0] hub_ttl_ms;
		logic [15:0] max_distance_cm;
		logic [15:0] dark_lux_level;
		logic [31:0] presence_hold_ms;
		logic [31:0] lux_max_age_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        button_level;
		logic        hub_valid;
		logic        hub_on;
		logic        lux_valid;
		logic [15:0] lux_value;
		logic        radar_valid;
		logic        presence;
		logic [15:0] moving_dist_cm;
		logic [15:0] static_dist_cm;
	} in_word_t;

	typedef struct packed {
		logic        light_on;
		logic        reason;
		logic [31:0] sequence_res;
	} out_word_t;

endpackage

### hw/rtl/olarb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olarb_cfg
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module olarb_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [olarb_pkg::ADDR_W-1:0] paddr,
	input  logic [olarb_pkg::DATA_W-1:0] pwdata,
	output logic [olarb_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output olarb_pkg::cfg_t              cfg
);

	olarb_pkg::cfg_t      cfg_q;
	olarb_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = olarb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_hold_ms     <= olarb_pkg::LONG_PRESS_RST;
			cfg_q.test_window_ms   <= olarb_pkg::TEST_WINDOW_RST;
			cfg_q.hub_ttl_ms       <= olarb_pkg::HUB_TTL_RST;
			cfg_q.max_distance_cm  <= olarb_pkg::MAX_DISTANCE_RST;
			cfg_q.dark_lux_level   <= olarb_pkg::DARK_LUX_RST;
			cfg_q.presence_hold_ms <= olarb_pkg::PRESENCE_HOLD_RST;
			cfg_q.lux_max_age_ms   <= olarb_pkg::LUX_MAX_AGE_RST;
		end else if (wr_en) begin
			unique case (idx)
				olarb_pkg::REG_LONG_PRESS:    cfg_q.long_hold_ms     <= pwdata;
				olarb_pkg::REG_TEST_WINDOW:   cfg_q.test_window_ms   <= pwdata;
				olarb_pkg::REG_HUB_TTL:       cfg_q.hub_ttl_ms       <= pwdata;
				olarb_pkg::REG_MAX_DISTANCE:  cfg_q.max_distance_cm  <= pwdata[15:0];
				olarb_pkg::REG_DARK_LUX:      cfg_q.dark_lux_level   <= pwdata[15:0];
				olarb_pkg::REG_PRESENCE_HOLD: cfg_q.presence_hold_ms <= pwdata;
				olarb_pkg::REG_LUX_MAX_AGE:   cfg_q.lux_max_age_ms   <= pwdata;
				default: ;   // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			olarb_pkg::REG_LONG_PRESS:    prdata = cfg_q.long_hold_ms;
			olarb_pkg::REG_TEST_WINDOW:   prdata = cfg_q.test_window_ms;
			olarb_pkg::REG_HUB_TTL:       prdata = cfg_q.hub_ttl_ms;
			olarb_pkg::REG_MAX_DISTANCE:  prdata = {16'd0, cfg_q.max_distance_cm};
			olarb_pkg::REG_DARK_LUX:      prdata = {16'd0, cfg_q.dark_lux_level};
			olarb_pkg::REG_PRESENCE_HOLD: prdata = cfg_q.presence_hold_ms;
			olarb_pkg::REG_LUX_MAX_AGE:   prdata = cfg_q.lux_max_age_ms;
			default:                      prdata = '0;
		endcase
	end

endmodule

### hw/rtl/olarb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olarb_core
// Arbiter state and single-pass lamp decision for one tick word.
// ----------------------------------------------------------------------------
module olarb_core #(
	parameter int SEQ_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  olarb_pkg::in_word_t  item,
	input  olarb_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output olarb_pkg::out_word_t res
);

	logic                 manual_q, test_q, last_button_q, long_done_q;
	logic                 hub_wants_q, hub_active_q, lux_seen_q, pres_seen_q, lamp_q;
	logic [31:0]          test_start_q, press_time_q, hub_time_q, lux_time_q, pres_time_q;
	logic [15:0]          lux_level_q;
	logic [SEQ_WIDTH-1:0] count_q;

	logic                 manual_n, test_n, last_button_n, long_done_n;
	logic                 hub_wants_n, hub_active_n, lux_seen_n, pres_seen_n, lamp_n;
	logic [31:0]          test_start_n, press_time_n, hub_time_n, lux_time_n, pres_time_n;
	logic [15:0]          lux_level_n;
	logic [SEQ_WIDTH-1:0] count_n;

	logic        btn, press_start, long_hit, short_press;
	logic        lamp_b, test_b, hub_act_b, near;
	logic        dark, hold, want, why;
	logic [31:0] now;
	logic [63:0] count_wide;

	assign now = item.now_ms;
	assign btn = item.button_level;

	always_comb begin
		// button: press edge, long hold, or short release
		press_start = !btn && last_button_q;
		long_hit    = !btn && !long_done_q && ((now - press_time_q) >= cfg.long_hold_ms);
		short_press = btn && !last_button_q && !long_done_q;

		manual_n     = manual_q;
		test_b       = test_q;
		test_start_n = test_start_q;
		press_time_n = press_time_q;
		long_done_n  = long_done_q;
		lamp_b       = lamp_q;
		priority if (press_start) begin
			press_time_n = now;
			long_done_n  = 1'b0;
		end else if (long_hit) begin
			manual_n    = !manual_q;
			long_done_n = 1'b1;
			test_b      = 1'b0;
		end else if (short_press) begin
			lamp_b = !lamp_q;
			if (!manual_q) begin
				test_b       = 1'b1;
				test_start_n = now;
			end
		end
		last_button_n = btn;

		test_n = test_b && !((now - test_start_n) > cfg.test_window_ms);

		hub_wants_n = item.hub_valid ? item.hub_on : hub_wants_q;
		hub_time_n  = item.hub_valid ? now : hub_time_q;
		hub_act_b   = item.hub_valid || hub_active_q;
		hub_active_n = hub_act_b && !((now - hub_time_n) > cfg.hub_ttl_ms);

		lux_level_n = item.lux_valid ? item.lux_value : lux_level_q;
		lux_time_n  = item.lux_valid ? now : lux_time_q;
		lux_seen_n  = item.lux_valid || lux_seen_q;

		// zero distance means no target of that kind
		near = item.radar_valid && item.presence &&
			(item.moving_dist_cm == 16'd0 || item.moving_dist_cm <= cfg.max_distance_cm) &&
			(item.static_dist_cm == 16'd0 || item.static_dist_cm <= cfg.max_distance_cm);
		pres_time_n = near ? now : pres_time_q;
		pres_seen_n = near || pres_seen_q;

		dark = !(lux_seen_n && ((now - lux_time_n) < cfg.lux_max_age_ms)) ||
			(lux_level_n < cfg.dark_lux_level);
		hold = pres_seen_n && ((now - pres_time_n) < cfg.presence_hold_ms);

		priority if (manual_n || test_n) begin
			want = lamp_b;
			why  = olarb_pkg::REASON_BUTTON;
		end else if (hub_active_n) begin
			want = hub_wants_n;
			why  = olarb_pkg::REASON_AUTO;
		end else begin
			want = hold && dark;
			why  = olarb_pkg::REASON_AUTO;
		end

		// a short press already emits and holds authority, so at most one word
		res_valid = short_press || (want != lamp_b);
		lamp_n    = short_press ? lamp_b : want;
		count_n   = res_valid ? count_q + SEQ_WIDTH'(1) : count_q;
		count_wide = 64'(count_n);

		res.light_on     = lamp_n;
		res.reason       = short_press ? olarb_pkg::REASON_BUTTON : why;
		res.sequence_res = count_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q      <= 1'b0;
			test_q        <= 1'b0;
			test_start_q  <= '0;
			last_button_q <= 1'b1;
			press_time_q  <= '0;
			long_done_q   <= 1'b0;
			hub_wants_q   <= 1'b0;
			hub_time_q    <= '0;
			hub_active_q  <= 1'b0;
			lux_level_q   <= olarb_pkg::LUX_LEVEL_RST;
			lux_time_q    <= '0;
			lux_seen_q    <= 1'b0;
			pres_time_q   <= '0;
			pres_seen_q   <= 1'b0;
			lamp_q        <= 1'b0;
			count_q       <= '0;
		end else if (fire) begin
			manual_q      <= manual_n;
			test_q        <= test_n;
			test_start_q  <= test_start_n;
			last_button_q <= last_button_n;
			press_time_q  <= press_time_n;
			long_done_q   <= long_done_n;
			hub_wants_q   <= hub_wants_n;
			hub_time_q    <= hub_time_n;
			hub_active_q  <= hub_active_n;
			lux_level_q   <= lux_level_n;
			lux_time_q    <= lux_time_n;
			lux_seen_q    <= lux_seen_n;
			pres_time_q   <= pres_time_n;
			pres_seen_q   <= pres_seen_n;
			lamp_q        <= lamp_n;
			count_q       <= count_n;
		end
	end

`ifndef SYNTHESIS
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> count_q == SEQ_WIDTH'($past(count_q) + SEQ_WIDTH'(1)))
		else $error("change count did not step on an emitted word");

	a_lamp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> lamp_q == $past(res.light_on))
		else $error("lamp state differs from emitted word");

	a_button_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.reason == olarb_pkg::REASON_BUTTON) |-> short_press)
		else $error("button reason without a short press");
`endif

endmodule

### hw/rtl/occupancy_light_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_light_arbiter
// Gate lamp arbiter: button, hub override and presence/lux rule by priority.
// ----------------------------------------------------------------------------
//  channel   handshake               word
//  in        in_valid / in_stall     in_data  (tick: time, button, hub, lux, radar)
//  out       out_valid / out_stall   out_data (lamp, reason, sequence)
//  cfg       psel/penable/pwrite     paddr, pwdata, prdata, pready
//
//  One tick per cycle unless the output stalls: input register, one decision
//  pass, result register. out_valid rises once an accepted tick has passed both
//  registers; ticks with no lamp change give no word.
//  arst_n clears valid flags and arbiter state and loads the register defaults.
//  A held output stalls the input register; in_stall rises only while it is full.
// ----------------------------------------------------------------------------
module occupancy_light_arbiter #(
	parameter int SEQ_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  olarb_pkg::in_word_t          in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output olarb_pkg::out_word_t         out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [olarb_pkg::ADDR_W-1:0] paddr,
	input  logic [olarb_pkg::DATA_W-1:0] pwdata,
	output logic [olarb_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);

	olarb_pkg::cfg_t      cfg;
	olarb_pkg::in_word_t  item_s1;
	olarb_pkg::out_word_t res;
	olarb_pkg::out_word_t out_q;
	logic                 valid_s1, out_valid_q, out_free, fire, accept, res_valid;

	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	olarb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	olarb_core #(
		.SEQ_WIDTH (SEQ_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with a free path");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> out_valid_q)
		else $error("decided word not loaded into output register");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled output word changed");
`endif

endmodule
